@@ sv/kufef_pkg.sv @@
package kufef_pkg;

    localparam int NODES_DEF = 1024;
    localparam int NODE_W = 10;
    localparam int WEIGHT_W = 32;

    localparam logic [NODE_W-1:0] NODE_COUNT_RST = 10'd1023;

    localparam logic MODE_CLEAR = 1'b0;
    localparam logic MODE_EDGE = 1'b1;

    typedef enum logic [1:0] {
        OUT_ACCEPT = 2'd0,
        OUT_SKIP   = 2'd1,
        OUT_RANGE  = 2'd2,
        OUT_CLEAR  = 2'd3
    } t_outcome;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_FIND,
        S_HALF,
        S_LINK_CHILD,
        S_LINK_ROOT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              mode;
        logic [NODE_W-1:0] end_a;
        logic [NODE_W-1:0] end_b;
        logic [WEIGHT_W-1:0] edge_weight;
    } t_in_item;

    typedef struct packed {
        t_outcome          outcome;
        logic [NODE_W-1:0] out_a;
        logic [NODE_W-1:0] out_b;
        logic [WEIGHT_W-1:0] out_weight;
    } t_out_item;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

@@ sv/kufef_mem.sv @@
module kufef_mem #(
    parameter int NODES = kufef_pkg::NODES_DEF
) (
    input  logic                      i_clk,
    input  kufef_pkg::t_mem_ctl       i_ctl,
    input  logic [$clog2(NODES)-1:0]  i_rd_addr,
    input  logic [$clog2(NODES)-1:0]  i_wr_addr,
    input  logic [$clog2(NODES)+$clog2(NODES+1)-1:0] i_wr_data,
    output logic [$clog2(NODES)+$clog2(NODES+1)-1:0] o_rd_data
);
    import kufef_pkg::*;

    localparam int ENT_W = $clog2(NODES) + $clog2(NODES + 1);

    logic [ENT_W-1:0] r_mem [NODES];
    logic [ENT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/kufef_ctrl.sv @@
module kufef_ctrl #(
    parameter int NODES = kufef_pkg::NODES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  kufef_pkg::t_in_item       i_in_data,
    input  logic [kufef_pkg::NODE_W-1:0] i_node_count,
    input  logic                      i_slot_free,
    output logic                      o_res_valid,
    output kufef_pkg::t_out_item      o_res_data,
    output kufef_pkg::t_mem_ctl       o_mem_ctl,
    output logic [$clog2(NODES)-1:0]  o_rd_addr,
    output logic [$clog2(NODES)-1:0]  o_wr_addr,
    output logic [$clog2(NODES)+$clog2(NODES+1)-1:0] o_wr_data,
    input  logic [$clog2(NODES)+$clog2(NODES+1)-1:0] i_rd_data
);
    import kufef_pkg::*;

    localparam int IDX_W = $clog2(NODES);
    localparam int SIZE_W = $clog2(NODES + 1);
    localparam int ENT_W = IDX_W + SIZE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

    t_state            r_state;
    t_state            n_state;
    logic [IDX_W-1:0]  r_clr;
    logic              r_clr_item;
    t_in_item          r_item;
    t_outcome          r_outcome;
    logic [IDX_W-1:0]  r_x;
    logic [SIZE_W-1:0] r_sx;
    logic              r_walk_b;
    logic [IDX_W-1:0]  r_ra;
    logic [SIZE_W-1:0] r_sa;
    logic [IDX_W-1:0]  r_rb;
    logic [SIZE_W-1:0] r_sb;

    logic [IDX_W-1:0]  w_p;
    logic [SIZE_W-1:0] w_s;
    logic              w_root;
    logic              w_range_bad;
    logic              w_a_small;
    logic [IDX_W-1:0]  w_big;

    assign w_p = i_rd_data[ENT_W-1:SIZE_W];
    assign w_s = i_rd_data[SIZE_W-1:0];
    assign w_root = (w_p == r_x);
    assign w_a_small = (r_sa < r_sb);
    assign w_big = w_a_small ? r_rb : r_ra;

    assign w_range_bad = (i_in_data.end_a > i_node_count)
                      || (i_in_data.end_b > i_node_count)
                      || (32'(i_in_data.end_a) >= NODES)
                      || (32'(i_in_data.end_b) >= NODES);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr == LAST_IDX) begin
                    n_state = r_clr_item ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.mode == MODE_CLEAR) begin
                        n_state = S_CLR;
                    end else if (w_range_bad) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (w_root) begin
                    if (r_walk_b) begin
                        n_state = (r_ra == r_x) ? S_DONE : S_LINK_CHILD;
                    end
                end else begin
                    n_state = S_HALF;
                end
            end
            S_HALF:       n_state = S_FIND;
            S_LINK_CHILD: n_state = S_LINK_ROOT;
            S_LINK_ROOT:  n_state = S_DONE;
            S_DONE: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default:      n_state = S_IDLE;
        endcase
    end

    // outputs and memory port
    always_comb begin
        o_in_ready = 1'b0;
        o_res_valid = 1'b0;
        o_mem_ctl = '0;
        o_rd_addr = r_x;
        o_wr_addr = r_x;
        o_wr_data = '0;
        case (r_state)
            S_CLR: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr = r_clr;
                o_wr_data = {r_clr, SIZE_W'(1)};
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_mem_ctl.rd_en = i_in_valid && (i_in_data.mode == MODE_EDGE) && !w_range_bad;
                o_rd_addr = IDX_W'(i_in_data.end_a);
            end
            S_FIND: begin
                if (w_root) begin
                    o_mem_ctl.rd_en = !r_walk_b;
                    o_rd_addr = IDX_W'(r_item.end_b);
                end else begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_rd_addr = w_p;
                end
            end
            S_HALF: begin
                // relink to grandparent and step there
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr = r_x;
                o_wr_data = {w_p, r_sx};
                o_mem_ctl.rd_en = 1'b1;
                o_rd_addr = w_p;
            end
            S_LINK_CHILD: begin
                o_mem_ctl.wr_en = 1'b1;
                if (w_a_small) begin
                    o_wr_addr = r_ra;
                    o_wr_data = {r_rb, r_sa};
                end else begin
                    o_wr_addr = r_rb;
                    o_wr_data = {r_ra, r_sb};
                end
            end
            S_LINK_ROOT: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr = w_big;
                o_wr_data = {w_big, SIZE_W'(r_sa + r_sb)};
            end
            S_DONE: begin
                o_res_valid = i_slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_res_data.outcome = r_outcome;
        if (r_outcome == OUT_CLEAR) begin
            o_res_data.out_a = '0;
            o_res_data.out_b = '0;
            o_res_data.out_weight = '0;
        end else begin
            o_res_data.out_a = r_item.end_a;
            o_res_data.out_b = r_item.end_b;
            o_res_data.out_weight = r_item.edge_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_clr_item <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + 1'b1;
            end else if (r_state == S_IDLE && i_in_valid) begin
                r_clr <= '0;
                r_clr_item <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_CLR: begin
                r_outcome <= OUT_CLEAR;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    r_item <= i_in_data;
                    r_x <= IDX_W'(i_in_data.end_a);
                    r_walk_b <= 1'b0;
                    r_outcome <= OUT_RANGE;
                end
            end
            S_FIND: begin
                if (w_root) begin
                    if (!r_walk_b) begin
                        r_ra <= r_x;
                        r_sa <= w_s;
                        r_x <= IDX_W'(r_item.end_b);
                        r_walk_b <= 1'b1;
                    end else begin
                        r_rb <= r_x;
                        r_sb <= w_s;
                        r_outcome <= (r_ra == r_x) ? OUT_SKIP : OUT_ACCEPT;
                    end
                end else begin
                    r_sx <= w_s;
                end
            end
            S_HALF: begin
                r_x <= w_p;
            end
            default: begin
                r_x <= r_x;
            end
        endcase
    end

endmodule

@@ sv/kruskal_union_find_edge_filter_core.sv @@
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_ready  o_out_data (t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (node_count)
//
// edge: a root walk with path halving from each end, plus the S_LINK_CHILD and S_LINK_ROOT writes
// when the edge is taken; each halving step reads the forest memory and writes one entry back
// out-of-range edge: the result is issued at once, the forest memory is not touched
// clear item: a sweep of every entry of the memory, then the result
// after reset the same sweep runs before the first transaction is taken
// a stalled output holds the next item at its result until the output register drains
module kruskal_union_find_edge_filter_core #(
    parameter int NODES = kufef_pkg::NODES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  kufef_pkg::t_in_item          i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output kufef_pkg::t_out_item         o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [kufef_pkg::NODE_W-1:0] i_cfg_data
);
    import kufef_pkg::*;

    localparam int IDX_W = $clog2(NODES);
    localparam int ENT_W = IDX_W + $clog2(NODES + 1);

    logic [NODE_W-1:0] r_node_count;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic              w_slot_free;
    logic              w_res_valid;
    t_out_item         w_res_data;
    t_mem_ctl          w_mem_ctl;
    logic [IDX_W-1:0]  w_rd_addr;
    logic [IDX_W-1:0]  w_wr_addr;
    logic [ENT_W-1:0]  w_wr_data;
    logic [ENT_W-1:0]  w_rd_data;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else if (i_cfg_valid) begin
            r_node_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out_data <= w_res_data;
        end
    end

    kufef_ctrl #(
        .NODES(NODES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_node_count (r_node_count),
        .i_slot_free  (w_slot_free),
        .o_res_valid  (w_res_valid),
        .o_res_data   (w_res_data),
        .o_mem_ctl    (w_mem_ctl),
        .o_rd_addr    (w_rd_addr),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data),
        .i_rd_data    (w_rd_data)
    );

    kufef_mem #(
        .NODES(NODES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (w_mem_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.mode == MODE_CLEAR) |=> !o_in_ready)
        else $error("input taken during forest sweep");

    a_res_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (!r_out_valid || i_out_ready))
        else $error("result overwrites a pending output");

    a_res_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !o_in_ready)
        else $error("result issued while accepting input");

endmodule
